// ===== rtl/hss_pkg.sv =====
package hss_pkg;

  typedef enum logic {
    TAG_SCRIPT,
    TAG_STYLE
  } tag_kind_t;

  // One word on the byte stream between stages; has clear marks an empty end-of-string word
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } hss_item_t;

  localparam logic [7:0] LT_CHAR = 8'h3C;

  localparam int SCRIPT_OPEN_LEN  = 6;
  localparam int SCRIPT_CLOSE_LEN = 9;
  localparam int STYLE_OPEN_LEN   = 5;
  localparam int STYLE_CLOSE_LEN  = 8;

  // First character sits in the top byte
  localparam logic [8*SCRIPT_OPEN_LEN-1:0]  SCRIPT_OPEN  = "script";
  localparam logic [8*SCRIPT_CLOSE_LEN-1:0] SCRIPT_CLOSE = "</script>";
  localparam logic [8*STYLE_OPEN_LEN-1:0]   STYLE_OPEN   = "style";
  localparam logic [8*STYLE_CLOSE_LEN-1:0]  STYLE_CLOSE  = "</style>";

  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic int open_len(tag_kind_t kind);
    return (kind == TAG_SCRIPT) ? SCRIPT_OPEN_LEN : STYLE_OPEN_LEN;
  endfunction

  function automatic int close_len(tag_kind_t kind);
    return (kind == TAG_SCRIPT) ? SCRIPT_CLOSE_LEN : STYLE_CLOSE_LEN;
  endfunction

  // Letter expected after the opening bracket, lower case
  function automatic logic [7:0] open_letter(tag_kind_t kind, int idx);
    logic [7:0] c;
    c = 8'h00;
    if (kind == TAG_SCRIPT) begin
      if (idx >= 0 && idx < SCRIPT_OPEN_LEN) begin
        c = SCRIPT_OPEN[8*(SCRIPT_OPEN_LEN-1-idx) +: 8];
      end
    end else begin
      if (idx >= 0 && idx < STYLE_OPEN_LEN) begin
        c = STYLE_OPEN[8*(STYLE_OPEN_LEN-1-idx) +: 8];
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] close_char(tag_kind_t kind, int idx);
    logic [7:0] c;
    c = 8'h00;
    if (kind == TAG_SCRIPT) begin
      if (idx >= 0 && idx < SCRIPT_CLOSE_LEN) begin
        c = SCRIPT_CLOSE[8*(SCRIPT_CLOSE_LEN-1-idx) +: 8];
      end
    end else begin
      if (idx >= 0 && idx < STYLE_CLOSE_LEN) begin
        c = STYLE_CLOSE[8*(STYLE_CLOSE_LEN-1-idx) +: 8];
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/hss_filter.sv =====
module hss_filter import hss_pkg::*; #(
  parameter tag_kind_t KIND = TAG_SCRIPT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  logic      en,
  input  logic      in_valid,
  output logic      in_ready,
  input  hss_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output hss_item_t out_item
);

  localparam int OPEN_LEN  = open_len(KIND);
  localparam int CLOSE_LEN = close_len(KIND);
  localparam int CW        = $clog2(OPEN_LEN + 1);
  localparam int KW        = $clog2(CLOSE_LEN);
  localparam int HD        = OPEN_LEN - 1;
  localparam int HW        = $clog2(HD);

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_MARK
  } tail_t;

  // Words owed for one accepted word: fcnt held bytes, then the tail
  typedef struct packed {
    logic [CW-1:0] fcnt;
    tail_t         tail;
    logic [7:0]    tbyte;
    logic          tlast;
  } plan_t;

  logic          skipping;
  logic          skipping_next;
  logic [CW-1:0] open_cnt;
  logic [CW-1:0] open_cnt_next;
  logic [KW-1:0] close_cnt;
  logic [KW-1:0] close_cnt_next;
  logic [7:0]    held [HD];
  logic          held_we;
  logic          busy;
  logic [CW-1:0] pos;
  plan_t         plan_reg;
  plan_t         plan_new;
  plan_t         plan_cur;
  logic [CW-1:0] e;
  logic [CW:0]   e1;
  logic          has_elem;
  logic          more;
  hss_item_t     elem;
  logic          can_load;
  logic          accept;
  logic          emit;
  logic          letter_match;
  logic          close_match;
  logic          is_lt;

  assign can_load = !out_valid || out_ready;
  assign in_ready = !busy && can_load;
  assign accept   = in_valid && in_ready;

  assign letter_match = fold_case(in_item.data) == open_letter(KIND, int'(open_cnt) - 1);
  assign close_match  = in_item.data == close_char(KIND, int'(close_cnt));
  assign is_lt        = in_item.data == LT_CHAR;

  always_comb begin
    plan_new       = '{fcnt: '0, tail: TAIL_NONE, tbyte: in_item.data, tlast: in_item.last};
    skipping_next  = skipping;
    open_cnt_next  = open_cnt;
    close_cnt_next = close_cnt;
    held_we        = 1'b0;
    if (!en) begin
      plan_new.tail  = in_item.has ? TAIL_BYTE : TAIL_MARK;
      plan_new.tbyte = in_item.has ? in_item.data : 8'h00;
    end else if (!in_item.has) begin
      // end of string from upstream with nothing attached: flush and reset
      plan_new.fcnt  = open_cnt;
      plan_new.tail  = (open_cnt == '0) ? TAIL_MARK : TAIL_NONE;
      plan_new.tbyte = 8'h00;
      skipping_next  = 1'b0;
      open_cnt_next  = '0;
      close_cnt_next = '0;
    end else if (skipping) begin
      if (close_match) begin
        if (int'(close_cnt) == CLOSE_LEN - 1) begin
          skipping_next  = 1'b0;
          close_cnt_next = '0;
        end else begin
          close_cnt_next = close_cnt + 1'b1;
        end
      end else begin
        close_cnt_next = is_lt ? KW'(1) : '0;
      end
      if (in_item.last) begin
        plan_new.tail  = TAIL_MARK;
        plan_new.tbyte = 8'h00;
        skipping_next  = 1'b0;
        close_cnt_next = '0;
      end
    end else if (open_cnt != '0 && letter_match) begin
      if (int'(open_cnt) == OPEN_LEN) begin
        // opening complete: drop held bytes, start skipping unless this byte ends the string
        skipping_next  = !in_item.last;
        open_cnt_next  = '0;
        close_cnt_next = '0;
        if (in_item.last) begin
          plan_new.tail  = TAIL_MARK;
          plan_new.tbyte = 8'h00;
        end
      end else begin
        held_we       = 1'b1;
        open_cnt_next = open_cnt + 1'b1;
        if (in_item.last) begin
          plan_new.fcnt = open_cnt + 1'b1;
          open_cnt_next = '0;
        end
      end
    end else begin
      // no partial opening, or it failed: flush what is held, then take the byte afresh
      plan_new.fcnt = open_cnt;
      if (is_lt && !in_item.last) begin
        open_cnt_next = CW'(1);
      end else begin
        open_cnt_next = '0;
        plan_new.tail = TAIL_BYTE;
      end
    end
  end

  always_comb begin
    plan_cur = busy ? plan_reg : plan_new;
    e        = busy ? pos : '0;
    e1       = {1'b0, e} + 1'b1;
    has_elem = (e < plan_cur.fcnt) || (e == plan_cur.fcnt && plan_cur.tail != TAIL_NONE);
    more     = (e1 < {1'b0, plan_cur.fcnt})
               || (e1 == {1'b0, plan_cur.fcnt} && plan_cur.tail != TAIL_NONE);
    if (e < plan_cur.fcnt) begin
      elem.data = (e == '0) ? LT_CHAR : held[HW'(e - 1'b1)];
      elem.has  = 1'b1;
      elem.last = plan_cur.tlast && plan_cur.tail == TAIL_NONE
                  && e1 == {1'b0, plan_cur.fcnt};
    end else begin
      elem.data = plan_cur.tbyte;
      elem.has  = plan_cur.tail == TAIL_BYTE;
      elem.last = plan_cur.tlast;
    end
    emit = (busy || accept) && can_load && has_elem;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      skipping  <= 1'b0;
      open_cnt  <= '0;
      close_cnt <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        skipping  <= skipping_next;
        open_cnt  <= open_cnt_next;
        close_cnt <= close_cnt_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
        busy      <= more;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[HW'(open_cnt - 1'b1)] <= in_item.data;
    end
    if (emit) begin
      out_item <= elem;
      pos      <= e1[CW-1:0];
      plan_reg <= plan_cur;
    end
  end

endmodule

// ===== rtl/hss_queue.sv =====
module hss_queue import hss_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  hss_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output hss_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  hss_item_t     slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = count != NW'(DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== rtl/html_script_style_stripper.sv =====
// Byte-stream HTML stripper. With html_mode set, blocks from a case-insensitive
// "<script" up to an exact "</script>" are dropped, then the same for "<style" /
// "</style>"; an unclosed block drops the rest of the string, and a partial opening
// is held back until it matches or fails. With html_mode clear, bytes pass unchanged.
// Throughput is one byte per cycle while the output is not held back. A failed
// partial opening, or the end of a string with bytes still held, makes that filter
// stage replay its held bytes one word per cycle, as the output allows, while it
// stalls its input. A string that leaves nothing to send ends in one word with tuser
// clear, tdata zero and tlast set. Data is registered in the script stage, then in
// the queue, then in the style stage. Writing html_mode clears both stages; write it
// only while the block is idle.
module html_script_style_stripper import hss_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       html_mode_we,
  input  logic       html_mode,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] has_byte
  output logic       m_axis_tlast
);

  logic      mode;
  hss_item_t in_item;
  logic      mid_valid;
  logic      mid_ready;
  hss_item_t mid_item;
  logic      q_valid;
  logic      q_ready;
  hss_item_t q_item;
  hss_item_t out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (html_mode_we) begin
      mode <= html_mode;
    end
  end

  assign in_item = '{data: s_axis_tdata, has: 1'b1, last: s_axis_tlast};

  hss_filter #(
    .KIND(TAG_SCRIPT)
  ) u_script (
    .clk      (clk),
    .rst      (rst),
    .clear    (html_mode_we),
    .en       (mode),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .out_valid(mid_valid),
    .out_ready(mid_ready),
    .out_item (mid_item)
  );

  hss_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_valid),
    .in_ready (mid_ready),
    .in_item  (mid_item),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_item (q_item)
  );

  hss_filter #(
    .KIND(TAG_STYLE)
  ) u_style (
    .clk      (clk),
    .rst      (rst),
    .clear    (html_mode_we),
    .en       (mode),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_item  (q_item),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_item (out_item)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tuser = out_item.has;
  assign m_axis_tlast = out_item.last;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hss_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SETTLE      = 24;      // three pipeline stages plus worst replay
  localparam int          HOLD_LEN    = 80;
  localparam int          MAX_KEPT    = 12;
  localparam logic [7:0]  BRACKET     = 8'h3C;

  typedef enum logic {
    ROW_WORD,
    ROW_MODE
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;    // byte to send, or html_mode in bit 0
    logic       eos;
    logic       typed;    // want holds the only word this row may produce
    hss_item_t  want;
  } dir_row_t;

  localparam hss_item_t NO_WORD = '0;
  localparam int        DIR_LEN = 29;

  localparam dir_row_t DIR_TAB [DIR_LEN] = '{
    '{ROW_WORD, 8'h01, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0}},
    '{ROW_WORD, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{ROW_WORD, 8'h3C, 1'b1, 1'b1, '{8'h3C, 1'b1, 1'b1}},
    '{ROW_MODE, 8'h01, 1'b0, 1'b0, NO_WORD},
    // unclosed mixed-case style block swallows the whole string: empty end word
    '{ROW_WORD, "<",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "s",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "T",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "y",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "L",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "e",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, ">",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    // partial opening still held at end of string
    '{ROW_WORD, "<",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "s",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "c",   1'b1, 1'b0, NO_WORD},
    // failed opening
    '{ROW_WORD, "<",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "b",   1'b1, 1'b0, NO_WORD},
    // mode write drops a held bracket
    '{ROW_WORD, "<",   1'b0, 1'b0, NO_WORD},
    '{ROW_MODE, 8'h01, 1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "z",   1'b1, 1'b1, '{"z", 1'b1, 1'b1}},
    // mode write leaves a script block being skipped
    '{ROW_WORD, "<",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "s",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "C",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "R",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "i",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "p",   1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "t",   1'b0, 1'b0, NO_WORD},
    '{ROW_MODE, 8'h01, 1'b0, 1'b0, NO_WORD},
    '{ROW_WORD, "a",   1'b1, 1'b1, '{"a", 1'b1, 1'b1}},
    '{ROW_MODE, 8'h00, 1'b0, 1'b0, NO_WORD}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       html_mode_we;
  logic       html_mode;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tuser;   // [0] has_byte
  logic       m_axis_tlast;

  html_script_style_stripper DUT (
    .clk           (clk),
    .rst           (rst),
    .html_mode_we  (html_mode_we),
    .html_mode     (html_mode),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // Stripper state, one slot per filter
  logic       html_on;
  logic       skipping  [2];
  int         open_cnt  [2];
  logic [7:0] held      [2][6];
  int         close_cnt [2];

  logic [7:0] script_out [$];
  logic [7:0] style_out  [$];
  hss_item_t  step_kept  [$];
  hss_item_t  kept_q     [$];
  logic [7:0] text_q     [$];

  hss_item_t  head;
  int         errors       = 0;
  int         words_in     = 0;
  int         words_out    = 0;
  int         strings_sent = 0;
  int         cycle_cnt    = 0;
  logic       tx_gaps      = 1'b1;
  logic       rx_stalls    = 1'b1;
  logic       hold_req     = 1'b0;

  function automatic void emit(tag_kind_t k, logic [7:0] b);
    if (k == TAG_SCRIPT) begin
      script_out.push_back(b);
    end else begin
      style_out.push_back(b);
    end
  endfunction

  function automatic void release_held(tag_kind_t k);
    for (int i = 0; i < open_cnt[k]; i++) begin
      emit(k, held[k][i]);
    end
    open_cnt[k] = 0;
  endfunction

  function automatic void end_filter(tag_kind_t k);
    release_held(k);
    skipping[k]  = 1'b0;
    close_cnt[k] = 0;
  endfunction

  function automatic void clear_filters();
    for (int k = 0; k < 2; k++) begin
      skipping[k]  = 1'b0;
      open_cnt[k]  = 0;
      close_cnt[k] = 0;
    end
  endfunction

  function automatic void strip_char(tag_kind_t k, logic [7:0] b);
    logic [7:0] folded;
    int         idx;
    string      word;
    string      closing;
    word    = (k == TAG_SCRIPT) ? "script" : "style";
    closing = (k == TAG_SCRIPT) ? "</script>" : "</style>";
    folded  = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    if (skipping[k]) begin
      // closing tag must match exactly; a bracket restarts the match
      if (close_cnt[k] < closing.len() && b == 8'(closing[close_cnt[k]])) begin
        close_cnt[k]++;
        if (close_cnt[k] >= closing.len()) begin
          skipping[k]  = 1'b0;
          close_cnt[k] = 0;
        end
      end else begin
        close_cnt[k] = (b == BRACKET) ? 1 : 0;
      end
      return;
    end
    if (open_cnt[k] > 0) begin
      idx = open_cnt[k] - 1;
      if (idx < word.len() && folded == 8'(word[idx])) begin
        if (idx + 1 >= word.len()) begin
          open_cnt[k]  = 0;
          skipping[k]  = 1'b1;
          close_cnt[k] = 0;
        end else if (open_cnt[k] < 6) begin
          held[k][open_cnt[k]] = b;
          open_cnt[k]++;
        end
        return;
      end
      release_held(k);
    end
    if (b == BRACKET) begin
      held[k][0]  = b;
      open_cnt[k] = 1;
    end else begin
      emit(k, b);
    end
  endfunction

  // Work out the words kept for one input byte
  function automatic void strip_step(logic [7:0] b, logic eos);
    int n;
    step_kept.delete();
    if (!html_on) begin
      step_kept.push_back('{data: b, has: 1'b1, last: eos});
      return;
    end
    script_out.delete();
    style_out.delete();
    strip_char(TAG_SCRIPT, b);
    if (eos) begin
      end_filter(TAG_SCRIPT);
    end
    foreach (script_out[i]) begin
      strip_char(TAG_STYLE, script_out[i]);
    end
    if (eos) begin
      end_filter(TAG_STYLE);
    end
    n = (style_out.size() > MAX_KEPT) ? MAX_KEPT : style_out.size();
    for (int i = 0; i < n; i++) begin
      step_kept.push_back('{data: style_out[i], has: 1'b1, last: eos && (i == n - 1)});
    end
    if (eos && n == 0) begin
      step_kept.push_back('{data: 8'h00, has: 1'b0, last: 1'b1});
    end
  endfunction

  function automatic logic [7:0] rand_char();
    string pool;
    pool = "<>/scriptyleSCRIPTYLE a";
    if ($urandom_range(0, 2) == 0) begin
      return 8'($urandom_range(1, 255));
    end
    return 8'(pool[$urandom_range(0, pool.len() - 1)]);
  endfunction

  function automatic void push_chars(string s, logic mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = 8'(s[i]);
      if (mix && c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
        c = c - 8'h20;
      end
      text_q.push_back(c);
    end
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eos, input logic typed,
                           input hss_item_t want);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    strip_step(b, eos);
    if (typed) begin
      kept_q.push_back(want);
    end else begin
      foreach (step_kept[i]) kept_q.push_back(step_kept[i]);
    end
    words_in++;
    if (eos) begin
      strings_sent++;
    end
    @(negedge clk);
  endtask

  // Stop offering and let every expected word drain out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    html_mode_we <= 1'b1;
    html_mode    <= v;
    @(negedge clk);
    html_mode_we <= 1'b0;
    html_on = v;
    clear_filters();
    @(negedge clk);
  endtask

  task automatic run_strings(input int target);
    int    stop_at;
    string word;
    stop_at = words_in + target;
    while (words_in < stop_at) begin
      text_q.delete();
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 8))
          0, 1: begin
            repeat ($urandom_range(1, 4)) text_q.push_back(rand_char());
          end
          2: begin
            push_chars("<script", 1'b1);
            repeat ($urandom_range(0, 3)) text_q.push_back(rand_char());
            if ($urandom_range(0, 3) == 0) begin
              push_chars("</SCRIPT>", 1'b0);
            end
            if ($urandom_range(0, 5) != 0) begin
              push_chars("</script>", 1'b0);
            end
          end
          3: begin
            push_chars("<style", 1'b1);
            repeat ($urandom_range(0, 3)) text_q.push_back(rand_char());
            if ($urandom_range(0, 5) != 0) begin
              push_chars("</style>", 1'b0);
            end
          end
          4: begin
            // opening that breaks off partway
            word = ($urandom_range(0, 1) == 1) ? "script" : "style";
            push_chars({"<", word.substr(0, $urandom_range(0, word.len() - 1) - 1)}, 1'b1);
            text_q.push_back(rand_char());
          end
          5: begin
            push_chars(($urandom_range(0, 1) == 1) ? "</script>" : "</style>", 1'b1);
          end
          6: begin
            push_chars("<ScRiPt", 1'b1);
            push_chars("</scrip<</SCRIPT></script>", 1'b0);
          end
          7: begin
            // script opening inside a style block
            push_chars("<style", 1'b1);
            push_chars("x<script>", 1'b0);
            push_chars("</style>", 1'b0);
          end
          default: begin
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
          end
        endcase
      end
      foreach (text_q[i]) begin
        send_word(text_q[i], i == text_q.size() - 1, 1'b0, NO_WORD);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (kept_q.size() == 0) begin
        $error("unexpected word: out_byte %h has_byte %b out_last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        head = kept_q.pop_front();
        if (m_axis_tdata !== head.data) begin
          $error("out_byte: expected %h, got %h", head.data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== head.has) begin
          $error("has_byte: expected %b, got %b", head.has, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== head.last) begin
          $error("out_last: expected %b, got %b", head.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, kept_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    html_mode_we  = 1'b0;
    html_mode     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    html_on       = 1'b0;
    clear_filters();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIR_LEN; r++) begin
      if (DIR_TAB[r].kind == ROW_MODE) begin
        wait_idle();
        write_mode(DIR_TAB[r].value[0]);
      end else begin
        send_word(DIR_TAB[r].value, DIR_TAB[r].eos, DIR_TAB[r].typed, DIR_TAB[r].want);
      end
    end

    // pass-through against a long receiver hold: fill the block and stall its input
    wait_idle();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_word(8'($urandom_range(1, 255)), (i == 19) || ($urandom_range(0, 5) == 0),
                1'b0, NO_WORD);
    end

    wait_idle();
    write_mode(1'b1);
    run_strings(30);

    // closing stretch without any idling
    wait_idle();
    write_mode(1'b0);
    write_mode(1'b1);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    run_strings(10);

    wait_idle();
    $display("Sent %0d words in %0d strings through pass-through and html stripping",
             words_in, strings_sent);
    $display("Checked %0d output words, %0d mismatches", words_out, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hss_pkg.sv
rtl/hss_filter.sv
rtl/hss_queue.sv
rtl/html_script_style_stripper.sv
tb/testbench.sv
